/* hdl/bstm_pkg.sv */
// Package for the binary square template search block.
// Holds shared widths, the configuration register map, pattern types and the result struct.
// No dependencies.
`default_nettype none

package bstm_pkg;

  // Window geometry and fixed field widths.
  localparam int WIN       = 6;
  localparam int PAT_W     = 6;
  localparam int ROW_W     = 32;
  localparam int FIELD_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ROW3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ROW4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ROW5 = 3'd5;

  typedef logic [PAT_W-1:0] pat_row_t;
  typedef pat_row_t         pat_t [WIN];
  typedef logic [ROW_W-1:0] row_t;
  typedef row_t             win_rows_t [WIN];

  // Default pattern: hollow square with a 2x2 core.
  localparam pat_t PAT_RESET = '{6'd63, 6'd33, 6'd45, 6'd45, 6'd33, 6'd63};

  // One search result.
  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] top_row;
    logic [FIELD_W-1:0] left_col;
  } res_t;

endpackage

`default_nettype wire

/* hdl/bstm_match.sv */
// Window comparator: checks every 6x6 window of six stacked rows against the pattern.
// Purely combinational; depends on bstm_pkg.
`default_nettype none

module bstm_match #(
  parameter int IMAGE_SIZE = 32
) (
  input  bstm_pkg::win_rows_t  rows,
  input  bstm_pkg::pat_t       pattern,
  output logic [IMAGE_SIZE-bstm_pkg::WIN:0] hit
);
  import bstm_pkg::*;

  localparam int NWIN  = IMAGE_SIZE - WIN + 1;

  // Pixel slices of each window; columns past the row width read as zero.
  wire [PAT_W-1:0] px [NWIN][WIN];

  for (genvar k = 0; k < NWIN; k++) begin : g_win
    for (genvar r = 0; r < WIN; r++) begin : g_row
      for (genvar b = 0; b < PAT_W; b++) begin : g_bit
        if (k + b < ROW_W) begin : g_in
          assign px[k][r][b] = rows[r][k+b];
        end else begin : g_out
          assign px[k][r][b] = 1'b0;
        end
      end
    end
  end

  // A window hits when all six of its rows equal the pattern rows.
  always_comb begin
    for (int k = 0; k < NWIN; k++) begin
      hit[k] = 1'b1;
      for (int r = 0; r < WIN; r++) begin
        if (px[k][r] != pattern[r]) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/bstm_core.sv */
// Search state: row history, row counter and the latched first match.
// Depends on bstm_pkg and bstm_match.
`default_nettype none

module bstm_core #(
  parameter int IMAGE_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  bstm_pkg::row_t    row,
  input  logic              first_row,
  input  bstm_pkg::pat_t    pattern,
  output logic              emit,
  output bstm_pkg::res_t    res
);
  import bstm_pkg::*;

  localparam int NWIN = IMAGE_SIZE - WIN + 1;
  localparam int CW   = $clog2(IMAGE_SIZE);
  localparam int WW   = (CW > FIELD_W) ? CW : FIELD_W;

  row_t               hist_r [WIN-1];
  logic [CW-1:0]      cnt_r;
  logic               seen_r;
  logic [FIELD_W-1:0] mrow_r;
  logic [FIELD_W-1:0] mcol_r;

  logic [CW-1:0]      idx;
  logic               seen_eff;
  logic [FIELD_W-1:0] mrow_eff;
  logic [FIELD_W-1:0] mcol_eff;
  logic               do_search;
  win_rows_t          rows;
  logic [NWIN-1:0]    hit;
  logic               any_hit;
  logic [FIELD_W-1:0] hit_col;
  logic [WW-1:0]      top_w;
  logic               seen_nxt;
  logic [FIELD_W-1:0] mrow_nxt;
  logic [FIELD_W-1:0] mcol_nxt;

  // Window stack: five stored rows above the incoming one.
  always_comb begin
    for (int r = 0; r < WIN - 1; r++) begin
      rows[r] = hist_r[r];
    end
    rows[WIN-1] = row;
  end

  bstm_match #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_match (
    .rows    (rows),
    .pattern (pattern),
    .hit     (hit)
  );

  // Leftmost hit wins.
  always_comb begin
    hit_col = '0;
    for (int k = NWIN - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_col = FIELD_W'(k);
      end
    end
    any_hit = |hit;
  end

  // A first-row request restarts the image before this row is searched.
  always_comb begin
    idx       = first_row ? '0 : cnt_r;
    seen_eff  = first_row ? 1'b0 : seen_r;
    mrow_eff  = first_row ? '0 : mrow_r;
    mcol_eff  = first_row ? '0 : mcol_r;
    do_search = (idx >= CW'(WIN - 1)) && !seen_eff;
    top_w     = WW'(idx) - WW'(WIN - 1);
    if (do_search && any_hit) begin
      seen_nxt = 1'b1;
      mrow_nxt = top_w[FIELD_W-1:0];
      mcol_nxt = hit_col;
    end else begin
      seen_nxt = seen_eff;
      mrow_nxt = mrow_eff;
      mcol_nxt = mcol_eff;
    end
    emit         = (idx == CW'(IMAGE_SIZE - 1));
    res.found    = seen_nxt;
    res.top_row  = seen_nxt ? mrow_nxt : '0;
    res.left_col = seen_nxt ? mcol_nxt : '0;
  end

  // Row history shifts on every processed row.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int r = 0; r < WIN - 2; r++) begin
        hist_r[r] <= hist_r[r+1];
      end
      hist_r[WIN-2] <= row;
    end
  end

  // Counter and match latch; both clear on reset and after the last row of an image.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      seen_r <= 1'b0;
      mrow_r <= '0;
      mcol_r <= '0;
    end else if (step) begin
      if (emit) begin
        cnt_r  <= '0;
        seen_r <= 1'b0;
        mrow_r <= '0;
        mcol_r <= '0;
      end else begin
        cnt_r  <= idx + CW'(1);
        seen_r <= seen_nxt;
        mrow_r <= mrow_nxt;
        mcol_r <= mcol_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/binary_square_template_search.sv */
// Binary 6x6 template search over a streamed one-bit image, one row per request.
// The result register is loaded when the last row of an image leaves the input register.
// Throughput: one row per cycle unless stalled; all windows of a row are compared combinationally.
// A held result only stalls the input if the next image finishes before it is taken.
// Reset (rst_n, synchronous, active low) clears the search and restores the default pattern.
// Depends on bstm_pkg and bstm_core.
`default_nettype none

module binary_square_template_search #(
  parameter int IMAGE_SIZE = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bstm_pkg::ROW_W-1:0]         in_row_bits,
  input  logic                               in_first_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [bstm_pkg::FIELD_W-1:0]       out_top_row,
  output logic [bstm_pkg::FIELD_W-1:0]       out_left_col,
  input  logic                               cfg_wr_en,
  input  logic [bstm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bstm_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import bstm_pkg::*;

  pat_t  pat_r;
  logic  s1_valid_r;
  row_t  s1_row_r;
  logic  s1_first_r;
  logic  out_valid_r;
  res_t  out_res_r;

  logic  advance;
  logic  emit;
  res_t  res;
  logic  in_accept;

  // Pattern registers; writes beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= PAT_RESET;
    end else if (cfg_wr_en && (cfg_index <= CFG_PATTERN_ROW5)) begin
      pat_r[cfg_index] <= cfg_data[PAT_W-1:0];
    end
  end

  // The held row moves on unless it ends an image while a result is still waiting.
  assign advance   = s1_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_row_r   <= in_row_bits;
      s1_first_r <= in_first_row;
    end
  end

  bstm_core #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .row       (s1_row_r),
    .first_row (s1_first_r),
    .pattern   (pat_r),
    .emit      (emit),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_res_r.found;
  assign out_top_row  = out_res_r.top_row;
  assign out_left_col = out_res_r.left_col;

  // A new result never lands on one that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  // The input only stalls when a row is held.
  a_stall_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  // A miss reports a zero position.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.found) |-> (out_res_r.top_row == '0 && out_res_r.left_col == '0))
    else $error("miss reported with nonzero position");

endmodule

`default_nettype wire

/* bench/binary_square_template_search_tb.sv */
// Testbench for binary_square_template_search: streams one-bit images row by row and
// checks each search result against a row-level predictor kept in the bench.
// Depends on bstm_pkg and the binary_square_template_search RTL.
module binary_square_template_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bstm_pkg::*;

  localparam int IMG       = 32;
  localparam int SETTLE    = 8;
  localparam int MAX_SHOWN = 10;
  localparam int LIMIT     = 200000;

  // Register indexes past the pattern rows; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] PAT_REG [WIN] = '{CFG_PATTERN_ROW0, CFG_PATTERN_ROW1,
      CFG_PATTERN_ROW2, CFG_PATTERN_ROW3, CFG_PATTERN_ROW4, CFG_PATTERN_ROW5};

  typedef enum int {BG_CLEAR, BG_SOLID, BG_NOISE, BG_SPARSE, BG_DENSE} bg_kind_t;

  typedef struct {
    row_t bits;
    logic first;
  } row_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  row_t                 in_row_bits = '0;
  logic                 in_first_row = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found;
  logic [FIELD_W-1:0]   out_top_row;
  logic [FIELD_W-1:0]   out_left_col;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Pending row requests and the search results they are expected to produce.
  row_req_t row_q [$];
  res_t     pending_matches [$];
  int       rows_pending = 0;

  // Predictor state: pattern copy, last five rows, position in image, latched match.
  pat_t               cur_pat = PAT_RESET;
  row_t               hist [WIN-1];
  int unsigned        rows_taken = 0;
  logic               hit = 1'b0;
  logic [FIELD_W-1:0] hit_row = '0;
  logic [FIELD_W-1:0] hit_col = '0;

  // Stimulus bookkeeping.
  row_t image_buf [IMG];
  int   gen_pos = 0;

  // Handshake pacing.
  int       row_gap = 0;
  bit       row_burst = 1'b0;
  bit       slot_free;
  row_req_t nxt;
  int       res_hold = 0;
  bit       res_burst = 1'b0;
  res_t     want;

  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  binary_square_template_search i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_row_bits (in_row_bits),
    .in_first_row(in_first_row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_found   (out_found),
    .out_top_row (out_top_row),
    .out_left_col(out_left_col),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < WIN-1; i++) hist[i] = '0;
  end

  // Advance the predicted search by one accepted row; a finished image queues its result.
  task automatic scan_row(input row_t bits, input logic first);
    int unsigned idx;
    int          left;
    int          r;
    logic        ok;
    row_t        w;
    res_t        res;
    idx = first ? 0 : rows_taken;
    if (first) begin
      hit = 1'b0;
      hit_row = '0;
      hit_col = '0;
    end
    if (idx >= WIN-1 && !hit) begin
      for (left = 0; left + WIN <= IMG; left++) begin
        ok = 1'b1;
        for (r = 0; r < WIN; r++) begin
          w = (r < WIN-1) ? hist[r] : bits;
          if (w[left +: PAT_W] != cur_pat[r]) ok = 1'b0;
        end
        if (ok && !hit) begin
          hit = 1'b1;
          hit_row = FIELD_W'(idx - (WIN-1));
          hit_col = FIELD_W'(left);
        end
      end
    end
    for (r = 0; r < WIN-2; r++) hist[r] = hist[r+1];
    hist[WIN-2] = bits;
    if (idx + 1 >= IMG) begin
      res.found = hit;
      res.top_row = hit ? hit_row : '0;
      res.left_col = hit ? hit_col : '0;
      pending_matches.push_back(res);
      rows_taken = 0;
      hit = 1'b0;
      hit_row = '0;
      hit_col = '0;
    end else begin
      rows_taken = idx + 1;
    end
  endtask

  // Row driver: random gap before each request, occasional stretches without gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      row_gap = $urandom_range(0, 8);
    end else begin
      slot_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        scan_row(in_row_bits, in_first_row);
        rows_pending--;
      end
      if (slot_free) begin
        if (row_gap != 0) begin
          row_gap--;
          in_valid <= 1'b0;
        end else if (row_q.size() != 0) begin
          nxt = row_q.pop_front();
          in_row_bits <= nxt.bits;
          in_first_row <= nxt.first;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) row_burst = !row_burst;
          row_gap = row_burst ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compare one field of a result and report the first few differences.
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, exp_v, act_v);
    end
  endtask

  // Result monitor: checks each accepted result and stalls the next result at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      res_hold = $urandom_range(0, 8);
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d: unexpected result found=%0d top=%0d left=%0d",
                     results_seen, out_found, out_top_row, out_left_col);
        end else begin
          want = pending_matches.pop_front();
          check_field("found", want.found, out_found);
          check_field("top_row", want.top_row, out_top_row);
          check_field("left_col", want.left_col, out_left_col);
        end
        results_seen++;
        if ($urandom_range(0, 7) == 0) res_burst = !res_burst;
        res_hold = res_burst ? 0 : $urandom_range(0, 8);
      end else if (out_valid && out_stall && res_hold != 0) begin
        res_hold--;
      end
      out_stall <= (res_hold != 0);
    end
  end

  // Cycle limit guarding against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("binary_square_template_search test failed");
      $finish;
    end
  end

  // Write one register while the block is idle and mirror it into the predictor.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input pat_row_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx <= CFG_PATTERN_ROW5) cur_pat[idx] = val;
  endtask

  // Wait until every request is taken and every result checked, then let the pipe settle.
  task automatic drain();
    while (rows_pending != 0 || pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int pick_pos();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return IMG - WIN;
      default: return $urandom_range(0, IMG - WIN);
    endcase
  endfunction

  task automatic fill_background(input bg_kind_t kind);
    for (int i = 0; i < IMG; i++) begin
      case (kind)
        BG_CLEAR:  image_buf[i] = '0;
        BG_SOLID:  image_buf[i] = '1;
        BG_NOISE:  image_buf[i] = $urandom;
        BG_SPARSE: image_buf[i] = $urandom & $urandom & $urandom;
        default:   image_buf[i] = $urandom | $urandom;
      endcase
    end
  endtask

  // Stamp the current pattern with its top-left corner at (top, left).
  task automatic plant(input int top, input int left);
    for (int r = 0; r < WIN; r++) image_buf[top + r][left +: PAT_W] = cur_pat[r];
  endtask

  // Queue the first len rows of the image buffer; first0 marks the opening row.
  task automatic send_image(input int len, input logic first0);
    row_req_t req;
    for (int i = 0; i < len; i++) begin
      req.bits = image_buf[i];
      req.first = (i == 0) ? first0 : 1'b0;
      row_q.push_back(req);
      rows_pending++;
    end
    gen_pos = (len == IMG) ? 0 : len;
  endtask

  // Mostly whole images with planted patterns; some cut short and restarted,
  // some opened without the first-row flag right after a finished image.
  task automatic random_image();
    int   len;
    logic first0;
    fill_background(bg_kind_t'($urandom_range(0, 4)));
    repeat ($urandom_range(0, 3)) plant(pick_pos(), pick_pos());
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, IMG - 1) : IMG;
    first0 = (gen_pos != 0) || ($urandom_range(0, 5) != 0);
    send_image(len, first0);
  endtask

  // Rewrite a random subset of pattern rows, extremes included, plus stray writes.
  task automatic random_pattern();
    pat_row_t v;
    for (int r = 0; r < WIN; r++) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = '1;
          default: v = pat_row_t'($urandom_range(0, 63));
        endcase
        set_reg(PAT_REG[r], v);
      end
    end
    if ($urandom_range(0, 2) == 0)
      set_reg($urandom_range(0, 1) ? CFG_SPARE6 : CFG_SPARE7,
              pat_row_t'($urandom_range(0, 63)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Default pattern. A short image holding a match is cut off by a restart,
    // then a full image on a solid background carries the match in the far corner.
    fill_background(BG_CLEAR);
    plant(0, 0);
    send_image(WIN, 1'b1);
    fill_background(BG_SOLID);
    image_buf[0] = '0;
    plant(IMG - WIN, IMG - WIN);
    send_image(IMG, 1'b1);
    repeat (6) random_image();
    drain();

    // All-zero pattern; writes past the last pattern row must change nothing.
    for (int r = 0; r < WIN; r++) set_reg(PAT_REG[r], '0);
    set_reg(CFG_SPARE6, '1);
    set_reg(CFG_SPARE7, 6'd21);
    fill_background(BG_CLEAR);
    send_image(IMG, 1'b1);
    repeat (6) random_image();
    drain();

    // All-one pattern.
    for (int r = 0; r < WIN; r++) set_reg(PAT_REG[r], '1);
    fill_background(BG_SOLID);
    send_image(IMG, 1'b1);
    repeat (6) random_image();
    drain();

    // Random pattern settings.
    repeat (6) begin
      random_pattern();
      repeat (7) random_image();
      drain();
    end

    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("binary_square_template_search test passed");
    end else begin
      $display("binary_square_template_search test failed");
    end
    $finish;
  end

endmodule

/* binary_square_template_search.f */
hdl/bstm_pkg.sv
hdl/bstm_match.sv
hdl/bstm_core.sv
hdl/binary_square_template_search.sv
bench/binary_square_template_search_tb.sv
